[rtl/tss_pkg.sv]
// ---------------------------------------------------------------------------
// tss_pkg
// Shared codes and controller-to-datapath command type for the two-stack
// shared-pool block.
// ---------------------------------------------------------------------------
package tss_pkg;

   localparam logic CMD_PUSH = 1'b0;
   localparam logic CMD_POP  = 1'b1;

   typedef enum logic [1:0] {
      ST_DONE  = 2'd0,
      ST_FULL  = 2'd1,
      ST_EMPTY = 2'd2
   } status_type;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;   // take the request beat and issue the memory reads
      logic commit;    // update pointers and memories, load the response
   } dp_cmd_type;

endpackage

[rtl/tss_req_if.sv]
// ---------------------------------------------------------------------------
// tss_req_if
// Request channel: push or pop command for one of the two stacks.
// ---------------------------------------------------------------------------
interface tss_req_if;
   logic               valid;
   logic               ready;
   logic               command;
   logic               stack_select;
   logic signed [31:0] push_value;

   modport source (output valid, output command, output stack_select,
                   output push_value, input ready);
   modport sink   (input valid, input command, input stack_select,
                   input push_value, output ready);
endinterface

[rtl/tss_rsp_if.sv]
// ---------------------------------------------------------------------------
// tss_rsp_if
// Response channel: popped value and completion status.
// ---------------------------------------------------------------------------
interface tss_rsp_if;
   logic               valid;
   logic               ready;
   logic signed [31:0] pop_value;
   logic [1:0]         status;

   modport source (output valid, output pop_value, output status, input ready);
   modport sink   (input valid, input pop_value, input status, output ready);
endinterface

[rtl/tss_ram.sv]
// ---------------------------------------------------------------------------
// tss_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module tss_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[raddr];
      end
   end

   assign rdata = rdata_ff;

endmodule

[rtl/tss_ctrl.sv]
// ---------------------------------------------------------------------------
// tss_ctrl
// Sequencer: takes a request beat, then commits it once the response
// register is free.
// ---------------------------------------------------------------------------
module tss_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output tss_pkg::dp_cmd_type    cmd
);
   import tss_pkg::*;

   typedef enum logic {
      S_IDLE,
      S_EXEC
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      out_free;

   assign out_free      = !rsp_valid_ff || rsp_ready;
   assign req_ready     = (state_ff == S_IDLE);
   assign rsp_valid     = rsp_valid_ff;
   assign cmd.capture   = (state_ff == S_IDLE) && req_valid;
   assign cmd.commit    = (state_ff == S_EXEC) && out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         // a commit reloads the response register, else a taken beat empties it
         priority if (state_ff == S_EXEC && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            S_IDLE: begin
               if (req_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               // hold here while the previous response is still unclaimed
               if (out_free) begin
                  state_ff <= S_IDLE;
               end
            end
            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

endmodule

[rtl/tss_datapath.sv]
// ---------------------------------------------------------------------------
// tss_datapath
// Slot pool, free-slot queue, stack tops and response register.
// ---------------------------------------------------------------------------
module tss_datapath #(
   parameter int POOL_DEPTH  = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic                clock,
   input  logic                reset,
   input  tss_pkg::dp_cmd_type cmd,
   input  logic                req_command,
   input  logic                req_stack_select,
   input  logic signed [31:0]  req_push_value,
   output logic signed [31:0]  rsp_pop_value,
   output logic [1:0]          rsp_status
);
   import tss_pkg::*;

   localparam int IdxW = $clog2(POOL_DEPTH);
   localparam int TopW = IdxW + 1;
   localparam logic [TopW-1:0] NullSlot = TopW'(POOL_DEPTH);
   localparam logic [IdxW-1:0] LastIdx  = IdxW'(POOL_DEPTH - 1);

   // captured request
   logic                   cmd_ff;
   logic                   sel_ff;
   logic [VALUE_WIDTH-1:0] val_ff;
   status_type             status_ff;

   // pool bookkeeping
   logic [TopW-1:0] top0_ff, top0_in;
   logic [TopW-1:0] top1_ff, top1_in;
   logic [IdxW-1:0] head_ff, head_in;
   logic [IdxW-1:0] tail_ff, tail_in;
   logic [TopW-1:0] count_ff, count_in;
   logic            first_pass_ff, first_pass_in;

   logic signed [31:0] rsp_value_ff;
   status_type         rsp_status_ff;

   // capture-side signals
   logic [TopW-1:0]        cap_top;
   status_type             cap_status;
   logic [63:0]            push_ext;

   // commit-side signals
   logic                   is_push;
   logic                   ok;
   logic [TopW-1:0]        cur_top;
   logic [IdxW-1:0]        free_slot;
   logic [TopW-1:0]        link_clamped;
   logic [TopW-1:0]        new_top;
   logic [63:0]            rd_ext;

   // memory ports
   logic [VALUE_WIDTH-1:0] value_rdata;
   logic [TopW-1:0]        link_rdata;
   logic [IdxW-1:0]        fifo_rdata;
   logic                   slot_we;
   logic                   fifo_we;
   logic                   slot_re;

   assign cap_top  = req_stack_select ? top1_ff : top0_ff;
   assign push_ext = {32'b0, req_push_value};

   always_comb begin
      priority if (req_command == CMD_PUSH && count_ff == '0) begin
         cap_status = ST_FULL;
      end else if (req_command == CMD_POP && cap_top >= NullSlot) begin
         cap_status = ST_EMPTY;
      end else begin
         cap_status = ST_DONE;
      end
   end

   // value and link are only read for a pop of a non-empty stack
   assign slot_re = cmd.capture && req_command == CMD_POP && cap_top < NullSlot;

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         cmd_ff    <= req_command;
         sel_ff    <= req_stack_select;
         val_ff    <= push_ext[VALUE_WIDTH-1:0];
         status_ff <= cap_status;
      end
   end

   assign is_push      = (cmd_ff == CMD_PUSH);
   assign ok           = (status_ff == ST_DONE);
   assign cur_top      = sel_ff ? top1_ff : top0_ff;
   // until the head has gone round once, queue entry i still holds index i
   assign free_slot    = first_pass_ff ? head_ff : fifo_rdata;
   assign link_clamped = (link_rdata > NullSlot) ? NullSlot : link_rdata;
   assign new_top      = is_push ? {1'b0, free_slot} : link_clamped;
   assign slot_we      = cmd.commit && ok && is_push;
   assign fifo_we      = cmd.commit && ok && !is_push;
   assign rd_ext       = 64'(value_rdata);

   always_comb begin
      top0_in       = top0_ff;
      top1_in       = top1_ff;
      head_in       = head_ff;
      tail_in       = tail_ff;
      count_in      = count_ff;
      first_pass_in = first_pass_ff;
      if (cmd.commit && ok) begin
         if (sel_ff) begin
            top1_in = new_top;
         end else begin
            top0_in = new_top;
         end
         if (is_push) begin
            head_in  = (head_ff == LastIdx) ? '0 : head_ff + IdxW'(1);
            count_in = count_ff - TopW'(1);
            if (head_ff == LastIdx) begin
               first_pass_in = 1'b0;
            end
         end else begin
            tail_in = (tail_ff == LastIdx) ? '0 : tail_ff + IdxW'(1);
            if (count_ff < NullSlot) begin
               count_in = count_ff + TopW'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         top0_ff       <= NullSlot;
         top1_ff       <= NullSlot;
         head_ff       <= '0;
         tail_ff       <= '0;
         count_ff      <= NullSlot;
         first_pass_ff <= 1'b1;
      end else begin
         top0_ff       <= top0_in;
         top1_ff       <= top1_in;
         head_ff       <= head_in;
         tail_ff       <= tail_in;
         count_ff      <= count_in;
         first_pass_ff <= first_pass_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.commit) begin
         rsp_status_ff <= status_ff;
         rsp_value_ff  <= (ok && !is_push) ? rd_ext[31:0] : 32'sd0;
      end
   end

   assign rsp_pop_value = rsp_value_ff;
   assign rsp_status    = rsp_status_ff;

   tss_ram #(.WIDTH(VALUE_WIDTH), .DEPTH(POOL_DEPTH)) u_values (
      .clock (clock),
      .we    (slot_we),
      .waddr (free_slot),
      .wdata (val_ff),
      .re    (slot_re),
      .raddr (cap_top[IdxW-1:0]),
      .rdata (value_rdata)
   );

   tss_ram #(.WIDTH(TopW), .DEPTH(POOL_DEPTH)) u_links (
      .clock (clock),
      .we    (slot_we),
      .waddr (free_slot),
      .wdata (cur_top),
      .re    (slot_re),
      .raddr (cap_top[IdxW-1:0]),
      .rdata (link_rdata)
   );

   tss_ram #(.WIDTH(IdxW), .DEPTH(POOL_DEPTH)) u_free_fifo (
      .clock (clock),
      .we    (fifo_we),
      .waddr (tail_ff),
      .wdata (cur_top[IdxW-1:0]),
      .re    (cmd.capture),
      .raddr (head_ff),
      .rdata (fifo_rdata)
   );

   // free count never exceeds the pool
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= NullSlot)
      else $error("free count above pool depth");

   // before the head wraps, the queue pointers alone give the free count
   a_first_pass_count: assert property (@(posedge clock) disable iff (reset)
      first_pass_ff |-> count_ff == NullSlot - {1'b0, head_ff} + {1'b0, tail_ff})
      else $error("free count disagrees with queue pointers");

   // a slot is never the top of both stacks
   a_tops_distinct: assert property (@(posedge clock) disable iff (reset)
      top0_ff < NullSlot |-> top0_ff != top1_ff)
      else $error("both stacks share a top slot");

   // a committed push always had a free slot
   a_push_has_slot: assert property (@(posedge clock) disable iff (reset)
      slot_we |-> count_ff != '0)
      else $error("push committed with no free slot");

endmodule

[rtl/two_stacks_shared_pool.sv]
// ---------------------------------------------------------------------------
// two_stacks_shared_pool
// Two stacks sharing one pool of linked slots, with a queue of free slots.
// ---------------------------------------------------------------------------
//  channel   dir   handshake      payload
//  req_bus   in    valid/ready    command, stack_select, push_value
//  rsp_bus   out   valid/ready    pop_value, status
//
//  one beat at a time: the accept cycle (S_IDLE) issues the slot and
//  free-queue memory reads, S_EXEC then commits on the registered data
//  reset is synchronous; no memory clearing pass
//  a finished response waits in the output register while one further beat
//  is taken; that beat is held in its commit cycle until the register frees
// ---------------------------------------------------------------------------
module two_stacks_shared_pool #(
   parameter int POOL_DEPTH  = 16,
   parameter int VALUE_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   tss_req_if.sink    req_bus,
   tss_rsp_if.source  rsp_bus
);
   import tss_pkg::*;

   dp_cmd_type cmd;

   tss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd)
   );

   tss_datapath #(.POOL_DEPTH(POOL_DEPTH), .VALUE_WIDTH(VALUE_WIDTH)) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_command      (req_bus.command),
      .req_stack_select (req_bus.stack_select),
      .req_push_value   (req_bus.push_value),
      .rsp_pop_value    (rsp_bus.pop_value),
      .rsp_status       (rsp_bus.status)
   );

endmodule
